/* rtl/switch_tap_gesture_decoder_macros.svh */
// Assertion macros for the switch tap gesture decoder RTL.
`ifndef SWITCH_TAP_GESTURE_DECODER_MACROS_SVH
`define SWITCH_TAP_GESTURE_DECODER_MACROS_SVH

`ifndef ASSERT_OFF

// Checks that the property holds at every clock edge outside reset.
`define STGD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("stgd assertion failed");

// Checks that the property never holds at any clock edge outside reset.
`define STGD_ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("stgd forbidden condition seen");

`else

`define STGD_ASSERT(lbl, clk, rst_n, prop)
`define STGD_ASSERT_NEVER(lbl, clk, rst_n, prop)

`endif

`endif

/* rtl/stgd_pkg.sv */
// Types and constants for the switch tap gesture decoder.
`default_nettype none

package stgd_pkg;

  localparam int unsigned TimeW = 32;

  // Configuration register indexes.
  localparam logic [1:0] RegDebounce = 2'd0;
  localparam logic [1:0] RegDecay    = 2'd1;
  localparam logic [1:0] RegFrame    = 2'd2;

  // Countdown thresholds in tenths of a second.
  localparam logic [5:0] ReloadTenths = 6'd50;
  localparam logic [5:0] TrimLimit    = 6'd25;
  localparam logic [5:0] CalLow       = 6'd21;
  localparam logic [5:0] CalHigh      = 6'd49;
  localparam logic [5:0] CalCancel    = 6'd20;

  // Gesture codes.
  localparam logic [3:0] GestNone   = 4'd0;
  localparam logic [3:0] GestSave   = 4'd4;
  localparam logic [3:0] GestCancel = 4'd6;
  localparam logic [3:0] GestCal    = 4'd8;
  localparam logic [3:0] GestTop    = 4'd12;

  localparam logic [7:0] TapsSave = 8'd4;
  localparam logic [7:0] TapsCal  = 8'd8;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        aux_on;
    logic        armed;
    logic        compass_busy;
  } req_t;

  typedef struct packed {
    logic       save_trim_active;
    logic       servo_trim_ok;
    logic       start_compass_cal;
    logic [7:0] tap_count;
    logic [3:0] gesture_value;
  } rsp_t;

  typedef struct packed {
    logic [9:0] debounce_ms;
    logic [9:0] decay_period_ms;
    logic [3:0] frame_type;
  } cfg_t;

  typedef struct packed {
    logic [7:0]       taps;
    logic [3:0]       gesture;
    logic [5:0]       countdown;
    logic [TimeW-1:0] last_on_ms;
    logic [TimeW-1:0] last_decay_ms;
    logic             save_trim;
    logic             servo_trim;
  } state_t;

endpackage

`default_nettype wire

/* rtl/stgd_update.sv */
// Next-state and result logic for one polling tick of the tap gesture decoder.
`default_nettype none

module stgd_update (
  input  wire stgd_pkg::state_t cur_i,
  input  wire stgd_pkg::req_t   req_i,
  input  wire stgd_pkg::cfg_t   cfg_i,
  output stgd_pkg::state_t      nxt_o,
  output stgd_pkg::rsp_t        rsp_o
);

  logic [stgd_pkg::TimeW-1:0] now;
  logic [stgd_pkg::TimeW-1:0] on_gap;
  logic [stgd_pkg::TimeW-1:0] decay_gap;
  logic                       frame_ok;
  logic                       cal;
  stgd_pkg::state_t           s;

  assign now       = req_i.now_ms[stgd_pkg::TimeW-1:0];
  assign on_gap    = now - cur_i.last_on_ms;
  assign decay_gap = now - cur_i.last_decay_ms;
  assign frame_ok  = (cfg_i.frame_type == 4'd3) || (cfg_i.frame_type == 4'd4) ||
                     (cfg_i.frame_type == 4'd5);

  always_comb begin
    s   = cur_i;
    cal = 1'b0;

    // A tap counts only after a long enough off gap; every on tick reloads.
    if (req_i.aux_on) begin
      if (on_gap > {{(stgd_pkg::TimeW-10){1'b0}}, cfg_i.debounce_ms}) begin
        s.taps = s.taps + 8'd1;
        if (s.gesture >= stgd_pkg::GestSave && s.gesture <= stgd_pkg::GestTop) begin
          s.gesture = s.gesture + 4'd1;
        end
      end
      s.countdown  = stgd_pkg::ReloadTenths;
      s.last_on_ms = now;
    end

    if (s.countdown != 6'd0 &&
        decay_gap > {{(stgd_pkg::TimeW-10){1'b0}}, cfg_i.decay_period_ms}) begin
      s.countdown     = s.countdown - 6'd1;
      s.last_decay_ms = now;
    end

    if (s.taps == stgd_pkg::TapsCal && !req_i.aux_on) begin
      s.taps = 8'd0;
    end
    if (!req_i.aux_on && s.countdown == 6'd0) begin
      s.taps = 8'd0;
    end

    if (s.taps == stgd_pkg::TapsSave && req_i.aux_on && !req_i.compass_busy) begin
      s.gesture = stgd_pkg::GestSave;
    end
    if (s.taps == stgd_pkg::TapsCal && req_i.aux_on) begin
      s.gesture = stgd_pkg::GestCal;
    end

    if (req_i.armed) begin
      if (s.gesture == stgd_pkg::GestSave && s.countdown <= stgd_pkg::TrimLimit) begin
        s.save_trim = 1'b1;
      end
      if (s.gesture == stgd_pkg::GestCancel && s.countdown <= stgd_pkg::TrimLimit) begin
        s.gesture   = stgd_pkg::GestNone;
        s.save_trim = 1'b0;
      end
    end else begin
      if (s.gesture == stgd_pkg::GestCal && s.countdown >= stgd_pkg::CalLow &&
          s.countdown <= stgd_pkg::CalHigh) begin
        cal = 1'b1;
      end
      if (s.gesture == stgd_pkg::GestCal && s.countdown == stgd_pkg::CalCancel) begin
        s.gesture = stgd_pkg::GestNone;
      end
      if (s.gesture == stgd_pkg::GestSave && s.countdown <= stgd_pkg::TrimLimit &&
          frame_ok) begin
        s.servo_trim = 1'b1;
      end
      if (s.gesture == stgd_pkg::GestCancel && s.countdown <= stgd_pkg::TrimLimit &&
          frame_ok) begin
        s.gesture    = stgd_pkg::GestNone;
        s.servo_trim = 1'b0;
      end
    end

    // Timeout: the top gesture falls back to the trim gesture while a trim
    // mode is active; codes 5, 7, 9 to 11 and 13 are simply dropped.
    if (s.countdown == 6'd0) begin
      if (s.gesture == stgd_pkg::GestTop) begin
        s.gesture = (s.save_trim || s.servo_trim) ? stgd_pkg::GestSave : stgd_pkg::GestNone;
      end
      if (s.gesture == 4'd5 || s.gesture == 4'd7 || s.gesture == 4'd9 ||
          s.gesture == 4'd10 || s.gesture == 4'd11 || s.gesture == 4'd13) begin
        s.gesture = stgd_pkg::GestNone;
      end
    end
  end

  assign nxt_o = s;

  assign rsp_o.save_trim_active  = s.save_trim;
  assign rsp_o.servo_trim_ok     = s.servo_trim;
  assign rsp_o.start_compass_cal = cal;
  assign rsp_o.tap_count         = s.taps;
  assign rsp_o.gesture_value     = s.gesture;

endmodule

`default_nettype wire

/* rtl/switch_tap_gesture_decoder.sv */
// A request is held in the input register, then its result in the result register.
// Throughput: one request per cycle while the result side does not stall; the update is a single combinational pass.
// While a result waits, an empty input register still takes one request; once both
// registers are full, a stall on the result side holds the request side too.
// Reset (asynchronous, active low) clears the decoder state and valid flags and
// loads the configuration defaults: debounce 50 ms, decay period 100 ms, frame type 0.
`default_nettype none

module switch_tap_gesture_decoder (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  // Request channel.
  input  wire logic           in_valid_i,
  output      logic           in_stall_o,
  input  wire stgd_pkg::req_t in_req_i,
  // Result channel.
  output      logic           out_valid_o,
  input  wire logic           out_stall_i,
  output stgd_pkg::rsp_t      out_rsp_o,
  // Configuration write channel.
  input  wire logic           cfg_valid_i,
  output      logic           cfg_ready_o,
  input  wire logic [1:0]     cfg_index_i,
  input  wire logic [9:0]     cfg_data_i
);

`include "switch_tap_gesture_decoder_macros.svh"

  // Input register, holding one request until the update can run on it.
  logic             in_valid_q, in_valid_d;
  stgd_pkg::req_t   in_req_q;

  // Result register.
  logic             out_valid_q, out_valid_d;
  stgd_pkg::rsp_t   out_rsp_q;

  // Decoder state and configuration.
  stgd_pkg::state_t state_q, state_d;
  stgd_pkg::cfg_t   cfg_q, cfg_d;
  stgd_pkg::rsp_t   rsp_d;

  logic out_free;
  logic fire;
  logic in_take;
  logic cal_bad;

  // The result register can be loaded when it is empty or being emptied now.
  assign out_free = !out_valid_q || !out_stall_i;
  // A held request is processed as soon as its result has somewhere to go.
  assign fire     = in_valid_q && out_free;
  // The input register only pushes back when its request is stuck behind a stalled result.
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_take ? 1'b1 : (fire ? 1'b0 : in_valid_q);
  assign out_valid_d = fire ? 1'b1 : (out_free ? 1'b0 : out_valid_q);

  stgd_update u_update (
    .cur_i (state_q),
    .req_i (in_req_q),
    .cfg_i (cfg_q),
    .nxt_o (state_d),
    .rsp_o (rsp_d)
  );

  // Configuration writes are always accepted; an index beyond the list is dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        stgd_pkg::RegDebounce: cfg_d.debounce_ms     = cfg_data_i;
        stgd_pkg::RegDecay:    cfg_d.decay_period_ms = cfg_data_i;
        stgd_pkg::RegFrame:    cfg_d.frame_type      = cfg_data_i[3:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q            <= 1'b0;
      out_valid_q           <= 1'b0;
      state_q               <= '0;
      cfg_q.debounce_ms     <= 10'd50;
      cfg_q.decay_period_ms <= 10'd100;
      cfg_q.frame_type      <= 4'd0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      cfg_q       <= cfg_d;
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_req_q <= in_req_i;
    end
    if (fire) begin
      out_rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  assign cal_bad = out_valid_q && out_rsp_q.start_compass_cal &&
                   (out_rsp_q.gesture_value != stgd_pkg::GestCal);

  // The countdown is reloaded to its top value and only ever decremented.
  `STGD_ASSERT(a_countdown_range, clk_i, rst_ni, state_q.countdown <= stgd_pkg::ReloadTenths)

  // A calibration request can only come with the calibration gesture still stored.
  `STGD_ASSERT_NEVER(a_cal_gesture, clk_i, rst_ni, cal_bad)

  // A request that is processed always leaves a result behind.
  `STGD_ASSERT(a_fire_result, clk_i, rst_ni, fire |=> out_valid_q)

  // Stall is only raised while a request sits in the input register.
  `STGD_ASSERT_NEVER(a_stall_empty, clk_i, rst_ni, in_stall_o && !in_valid_q)

endmodule

`default_nettype wire

/* tb/sv/stgd_tick_checker.sv */
// Checker that predicts and compares every result of the switch tap gesture decoder.
`timescale 1ns / 100ps

module stgd_tick_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  stgd_pkg::req_t  in_req_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  stgd_pkg::rsp_t  out_rsp_i,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [9:0]      cfg_data_i,
  output int unsigned     errors_o,
  output int unsigned     pending_o
);

  import stgd_pkg::*;

  localparam logic [3:0] FrameTrimLo = 4'd3;
  localparam logic [3:0] FrameTrimHi = 4'd5;
  localparam logic [3:0] GestLast    = 4'd13;
  localparam logic [9:0] DebounceRst = 10'd50;
  localparam logic [9:0] DecayRst    = 10'd100;

  logic [9:0]       cfg_debounce;
  logic [9:0]       cfg_decay;
  logic [3:0]       cfg_frame;
  logic [7:0]       tap_ctr;
  logic [3:0]       gest;
  logic [5:0]       tenths;
  logic [TimeW-1:0] last_on;
  logic [TimeW-1:0] last_decay;
  logic             save_trim;
  logic             servo_trim;

  rsp_t        gesture_report_q[$];
  rsp_t        want;
  int unsigned mismatches;

  assign errors_o = mismatches;

  // Applies one polling tick to the mirrored decoder state and returns its report.
  function automatic rsp_t decode_tick(input req_t r);
    logic [TimeW-1:0] since_on;
    logic [TimeW-1:0] since_decay;
    logic             cal;
    logic             frame_ok;
    rsp_t             o;
    since_on    = r.now_ms - last_on;
    since_decay = r.now_ms - last_decay;
    cal         = 1'b0;
    frame_ok    = (cfg_frame >= FrameTrimLo) && (cfg_frame <= FrameTrimHi);

    if (r.aux_on) begin
      if (since_on > cfg_debounce) begin
        tap_ctr = tap_ctr + 8'd1;
        if (gest >= GestSave && gest <= GestTop) gest = gest + 4'd1;
      end
      tenths  = ReloadTenths;
      last_on = r.now_ms;
    end

    if (tenths != '0 && since_decay > cfg_decay) begin
      tenths     = tenths - 6'd1;
      last_decay = r.now_ms;
    end

    if (tap_ctr == TapsCal && !r.aux_on) tap_ctr = '0;
    if (!r.aux_on && tenths == '0) tap_ctr = '0;
    if (tap_ctr == TapsSave && r.aux_on && !r.compass_busy) gest = GestSave;
    if (tap_ctr == TapsCal && r.aux_on) gest = GestCal;

    if (r.armed) begin
      if (gest == GestSave && tenths <= TrimLimit) save_trim = 1'b1;
      if (gest == GestCancel && tenths <= TrimLimit) begin
        gest      = GestNone;
        save_trim = 1'b0;
      end
    end else begin
      if (gest == GestCal && tenths >= CalLow && tenths <= CalHigh) cal = 1'b1;
      if (gest == GestCal && tenths == CalCancel) gest = GestNone;
      if (gest == GestSave && tenths <= TrimLimit && frame_ok) servo_trim = 1'b1;
      if (gest == GestCancel && tenths <= TrimLimit && frame_ok) begin
        gest       = GestNone;
        servo_trim = 1'b0;
      end
    end

    // Once the countdown has run out, unfinished gestures lapse.
    if (tenths == '0) begin
      if (gest == GestTop) gest = (save_trim || servo_trim) ? GestSave : GestNone;
      if ((gest > GestSave && gest < GestCal && gest != GestCancel) ||
          (gest > GestCal && gest <= GestLast && gest != GestTop)) gest = GestNone;
    end

    o.save_trim_active  = save_trim;
    o.servo_trim_ok     = servo_trim;
    o.start_compass_cal = cal;
    o.tap_count         = tap_ctr;
    o.gesture_value     = gest;
    return o;
  endfunction

  task automatic compare_field(input string name, input int unsigned exp_v,
                               input int unsigned got_v);
    if (exp_v != got_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_debounce = DebounceRst;
      cfg_decay    = DecayRst;
      cfg_frame    = '0;
      tap_ctr      = '0;
      gest         = GestNone;
      tenths       = '0;
      last_on      = '0;
      last_decay   = '0;
      save_trim    = 1'b0;
      servo_trim   = 1'b0;
      mismatches   = 0;
      gesture_report_q.delete();
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegDebounce: cfg_debounce = cfg_data_i;
          RegDecay:    cfg_decay    = cfg_data_i;
          RegFrame:    cfg_frame    = cfg_data_i[3:0];
          default: ;
        endcase
      end
      // Results are matched before this edge's request is predicted.
      if (out_valid_i && !out_stall_i) begin
        if (gesture_report_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: result with no request outstanding", $time);
        end else begin
          want = gesture_report_q.pop_front();
          compare_field("save_trim_active", want.save_trim_active,
                        out_rsp_i.save_trim_active);
          compare_field("servo_trim_ok", want.servo_trim_ok, out_rsp_i.servo_trim_ok);
          compare_field("start_compass_cal", want.start_compass_cal,
                        out_rsp_i.start_compass_cal);
          compare_field("tap_count", want.tap_count, out_rsp_i.tap_count);
          compare_field("gesture_value", want.gesture_value, out_rsp_i.gesture_value);
        end
      end
      if (in_valid_i && !in_stall_i) gesture_report_q.push_back(decode_tick(in_req_i));
      pending_o = gesture_report_q.size();
    end
  end

endmodule

/* tb/sv/tb_switch_tap_gesture_decoder.sv */
// Stimulus and verdict for the switch tap gesture decoder, with its checker beside it.
`timescale 1ns / 100ps

module tb_switch_tap_gesture_decoder;

  import stgd_pkg::*;

  // Index that decodes to no register; writes to it must be ignored.
  localparam logic [1:0] RegSpare = 2'd3;

  logic       clk      = 1'b0;
  logic       rst_n    = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  req_t       in_req   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  rsp_t       out_rsp;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = RegDebounce;
  logic [9:0] cfg_data  = '0;

  int unsigned mismatch_total;
  int unsigned pending_count;

  // Mirror of the timing registers, used only to shape the tick spacing.
  logic [9:0]  deb_ms   = 10'd50;
  logic [9:0]  dec_ms   = 10'd100;
  logic [31:0] clock_ms = '0;
  int          items_sent = 0;
  // While set, neither side inserts gaps or stalls.
  bit          calm = 1'b0;

  switch_tap_gesture_decoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  stgd_tick_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_i   (out_rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .errors_o    (mismatch_total),
    .pending_o   (pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The result side stalls at random about eight percent of the time, except in the calm stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 8);
    end
  end

  // Sends one polling tick, delta milliseconds after the previous one. The task
  // returns at the edge where the request was taken, with valid still high, so
  // that back-to-back requests never drop valid in between.
  task automatic send_tick(input logic [31:0] delta, input bit aux, input bit armed,
                           input bit busy);
    req_t r;
    while (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    clock_ms       = clock_ms + delta;
    r.now_ms       = clock_ms;
    r.aux_on       = aux;
    r.armed        = armed;
    r.compass_busy = busy;
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    items_sent++;
    // A stretch in the middle of the run goes without any gaps or stalls.
    calm = (items_sent >= 300) && (items_sent < 420);
  endtask

  // Drops valid and waits, at falling edges so as not to race the checker, until
  // every request has had its result. Returns aligned to a rising edge.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    @(posedge clk);
  endtask

  // Writes the three registers back to back, optionally followed by a write to
  // the unused index. Valid stays high between the writes.
  task automatic load_settings(input logic [9:0] deb, input logic [9:0] dec,
                               input logic [9:0] frame_word, input bit with_spare);
    logic [1:0] idx[4];
    logic [9:0] val[4];
    int         n;
    int         k;
    idx[0] = RegDebounce; val[0] = deb;
    idx[1] = RegDecay;    val[1] = dec;
    idx[2] = RegFrame;    val[2] = frame_word;
    idx[3] = RegSpare;    val[3] = 10'($urandom_range(1023));
    n = with_spare ? 4 : 3;
    for (k = 0; k < n; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    deb_ms = deb;
    dec_ms = dec;
  endtask

  // A tap gesture as a pilot would make it: taps spaced just past the debounce
  // time, sometimes with the switch held on between taps or with an early
  // contact bounce, then a quiet tail while the countdown decays. The armed and
  // busy levels glitch now and then to break the sequence.
  task automatic run_gesture(input int taps_n, input bit armed, input bit busy,
                             input int tail_n);
    int k;
    bit held;
    for (k = 0; k < taps_n; k++) begin
      held = (k > 0) && ($urandom_range(99) < 20);
      if ($urandom_range(99) < 8) send_tick($urandom_range(deb_ms), 1'b1, armed, busy);
      send_tick(deb_ms + 1 + $urandom_range(20), 1'b1,
                armed ^ ($urandom_range(99) < 3), busy ^ ($urandom_range(99) < 3));
      if (!held) send_tick($urandom_range(30), 1'b0, armed, busy);
    end
    for (k = 0; k < tail_n; k++) begin
      send_tick(($urandom_range(99) < 5) ? 0 : dec_ms + $urandom_range(2), 1'b0,
                armed ^ ($urandom_range(99) < 3), busy);
    end
  endtask

  // Mostly well-formed gestures with random content; the rest are ticks at
  // arbitrary absolute times with random levels.
  task automatic run_random(input int quota);
    int first;
    int taps_n;
    first = items_sent;
    while (items_sent - first < quota) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 6)) begin
          clock_ms = $urandom;
          send_tick(0, 1'($urandom_range(1)), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
        end
      end else begin
        case ($urandom_range(7))
          0: taps_n = 4;
          1: taps_n = 6;
          2: taps_n = 8;
          3: taps_n = 12;
          4: taps_n = 13;
          default: taps_n = $urandom_range(1, 13);
        endcase
        run_gesture(taps_n, 1'($urandom_range(1)), $urandom_range(99) < 15,
                    $urandom_range(5, 60));
      end
    end
  endtask

  initial begin
    int k;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: debounce 50 ms, decay period 100 ms, frame type 0.
    // A tap at the very same time as the last one, one exactly on the debounce
    // boundary, one just past it, then the clock at all ones and wrapping to zero.
    send_tick(32'd0, 1'b1, 1'b0, 1'b0);
    send_tick(32'd50, 1'b1, 1'b0, 1'b0);
    send_tick(32'd51, 1'b1, 1'b0, 1'b0);
    send_tick(32'd100, 1'b0, 1'b1, 1'b1);
    clock_ms = 32'hFFFF_FFFF;
    send_tick(32'd0, 1'b1, 1'b1, 1'b1);
    send_tick(32'd1, 1'b0, 1'b0, 1'b0);
    // A four-tap gesture while armed; its tail is too short for the countdown to reach the save-trim limit.
    run_gesture(4, 1'b1, 1'b0, 18);
    run_random(40);

    // No debounce and a zero decay period, where any advance of time counts.
    // The switch is then held on for over 256 ticks so that the tap counter wraps.
    settle();
    load_settings(10'd0, 10'd0, 10'd3, 1'b0);
    for (k = 0; k < 264; k++)
      send_tick(32'd1, 1'b1, $urandom_range(99) < 50, $urandom_range(99) < 10);
    run_random(40);

    // Longest timings, with junk in the unused frame bits and a write to the
    // spare index; time starts just short of the wrap.
    settle();
    load_settings(10'd1023, 10'd1023, 10'h3F5, 1'b1);
    clock_ms = 32'hFFFF_C000;
    run_random(40);

    settle();
    load_settings(10'($urandom_range(200)), 10'($urandom_range(1, 200)), 10'd4, 1'b0);
    run_random(40);

    settle();
    load_settings(10'd50, 10'd1, 10'($urandom_range(15)), 1'b1);
    run_random(40);

    // Let the last results drain and give any stray result time to show.
    settle();
    repeat (10) @(posedge clk);
    if (mismatch_total == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* switch_tap_gesture_decoder.f */
+incdir+rtl
rtl/stgd_pkg.sv
rtl/stgd_update.sv
rtl/switch_tap_gesture_decoder.sv
tb/sv/stgd_tick_checker.sv
tb/sv/tb_switch_tap_gesture_decoder.sv
